// ===== sv/composite_sync_decoder_macros.svh =====
// assertion macros shared by the composite sync decoder rtl
`ifndef COMPOSITE_SYNC_DECODER_MACROS_SVH
`define COMPOSITE_SYNC_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define CSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define CSD_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSD_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== sv/csd_pkg.sv =====
// types, constants and helpers of the composite sync decoder
`timescale 1ns / 1ps

package csd_pkg;

  localparam int CNT_W = 10;
  localparam int THR_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

  // line limits per standard
  localparam logic [CNT_W-1:0] PAL_ACTIVE_LINES  = 10'd288;
  localparam logic [CNT_W-1:0] PAL_BLANK_LINES   = 10'd24;
  localparam logic [CNT_W-1:0] NTSC_ACTIVE_LINES = 10'd252;
  localparam logic [CNT_W-1:0] NTSC_BLANK_LINES  = 10'd21;

  // configuration register indexes
  localparam logic [1:0] REG_SHORT_THR  = 2'd0;
  localparam logic [1:0] REG_HALF_THR   = 2'd1;
  localparam logic [1:0] REG_PAL_BROAD  = 2'd2;
  localparam logic [1:0] REG_NTSC_BROAD = 2'd3;

  // reported phase codes
  localparam logic [2:0] PHC_UNKNOWN = 3'd0;
  localparam logic [2:0] PHC_PRE     = 3'd1;
  localparam logic [2:0] PHC_BROAD   = 3'd2;
  localparam logic [2:0] PHC_POST    = 3'd3;
  localparam logic [2:0] PHC_ACTIVE  = 3'd4;

  typedef enum logic [1:0] {
    KIND_HALF_LONG  = 2'd0,
    KIND_HALF_SHORT = 2'd1,
    KIND_FULL_SHORT = 2'd2,
    KIND_FULL_LONG  = 2'd3
  } pulse_kind_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_BLANK = 2'd1,
    ACT_VIDEO = 2'd2
  } line_action_t;

  typedef enum logic [4:0] {
    PH_UNKNOWN = 5'b00001,
    PH_PRE     = 5'b00010,
    PH_BROAD   = 5'b00100,
    PH_POST    = 5'b01000,
    PH_ACTIVE  = 5'b10000
  } phase_t;

  // one classified pulse moving between front, queue and back
  typedef struct packed {
    logic        valid;
    pulse_kind_t kind;
  } csd_xfer_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_UNKNOWN: code = PHC_UNKNOWN;
      PH_PRE:     code = PHC_PRE;
      PH_BROAD:   code = PHC_BROAD;
      PH_POST:    code = PHC_POST;
      PH_ACTIVE:  code = PHC_ACTIVE;
      default:    code = PHC_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/csd_if.sv =====
// valid/ready channel interfaces of the composite sync decoder
`timescale 1ns / 1ps

interface csd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_period;
  logic [15:0] sync_width;

  modport source(output valid, line_period, sync_width, input ready);
  modport sink(input valid, line_period, sync_width, output ready);
endinterface

interface csd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pulse_kind;
  logic [2:0] sync_phase;
  logic       locked;
  logic       field_parity;
  logic [9:0] standard_count;
  logic [9:0] line_number;
  logic [1:0] line_action;
  logic       field_start;
  logic       frame_start;
  logic       sync_lost;

  modport source(output valid, pulse_kind, sync_phase, locked, field_parity,
                 standard_count, line_number, line_action, field_start,
                 frame_start, sync_lost, input ready);
  modport sink(input valid, pulse_kind, sync_phase, locked, field_parity,
               standard_count, line_number, line_action, field_start,
               frame_start, sync_lost, output ready);
endinterface

// ===== sv/composite_sync_decoder.sv =====
// top level of the composite sync decoder: config registers, front, queue, back
`timescale 1ns / 1ps

// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | line_period, sync_width
// out_ch   | out | valid/ready        | pulse_kind .. sync_lost, one per input
// cfg_*    | in  | cfg_we, no wait    | cfg_index selects register, cfg_wdata
//
// one interval per cycle sustained while out_ch takes every result; a transfer
// on in_ch is classified at once and queued, the back end takes it from the
// queue once the result register is free or emptying and registers its result
// the phase machine update in the back end is combinational, once per item
// synchronous active-low reset clears queue, phase machine and counters and
// loads the register defaults
// a stalled out_ch holds the result register; the queue keeps accepting until
// full, then in_ch.ready drops

module composite_sync_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  csd_in_if.sink      in_ch,
  csd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import csd_pkg::*;

  // threshold and standard registers
  logic [THR_W-1:0] short_thr_r;
  logic [THR_W-1:0] half_thr_r;
  logic [CNT_W-1:0] pal_broad_r;
  logic [CNT_W-1:0] ntsc_broad_r;

  // front to queue and queue to back transfers
  csd_xfer_t push;
  logic      push_ready;
  csd_xfer_t pop;
  logic      pop_ready;

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r  <= 16'd839;
      half_thr_r   <= 16'd2855;
      pal_broad_r  <= 10'd5;
      ntsc_broad_r <= 10'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_THR:  short_thr_r  <= cfg_wdata;
        REG_HALF_THR:   half_thr_r   <= cfg_wdata;
        REG_PAL_BROAD:  pal_broad_r  <= cfg_wdata[CNT_W-1:0];
        REG_NTSC_BROAD: ntsc_broad_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // classify each interval as half/full line and short/long sync
  csd_front u_front (
    .in_ch      (in_ch),
    .short_thr  (short_thr_r),
    .half_thr   (half_thr_r),
    .push       (push),
    .push_ready (push_ready)
  );

  // decouples input acceptance from result stalls
  csd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  // phase tracking, standard learning, line counting and result register
  csd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_ready  (pop_ready),
    .pal_count  (pal_broad_r),
    .ntsc_count (ntsc_broad_r),
    .out_ch     (out_ch)
  );

endmodule

// ===== sv/csd_front.sv =====
// front end: takes sync intervals and classifies them into pulse kinds
`timescale 1ns / 1ps

module csd_front (
  csd_in_if.sink                        in_ch,
  input  logic [csd_pkg::THR_W-1:0]     short_thr,
  input  logic [csd_pkg::THR_W-1:0]     half_thr,
  output csd_pkg::csd_xfer_t            push,
  input  logic                          push_ready
);
  import csd_pkg::*;

  logic is_half;
  logic is_short;

  assign is_half  = (in_ch.line_period <= half_thr);
  assign is_short = (in_ch.sync_width <= short_thr);

  always_comb begin
    push.valid = in_ch.valid;
    if (is_half) begin
      push.kind = is_short ? KIND_HALF_SHORT : KIND_HALF_LONG;
    end else begin
      push.kind = is_short ? KIND_FULL_SHORT : KIND_FULL_LONG;
    end
  end

  assign in_ch.ready = push_ready;

endmodule

// ===== sv/csd_queue.sv =====
// short fifo of classified pulses between front and back
`timescale 1ns / 1ps
`include "composite_sync_decoder_macros.svh"

module csd_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csd_pkg::csd_xfer_t push,
  output logic               push_ready,
  output csd_pkg::csd_xfer_t pop,
  input  logic               pop_ready
);
  import csd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CW-1:0]    FULL_CNT = CW'(DEPTH);

  pulse_kind_t      kind_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != FULL_CNT);
  assign push_fire  = push.valid && push_ready;
  assign pop.valid  = (count_r != '0);
  assign pop.kind   = kind_mem_r[rd_ptr_r];
  assign pop_fire   = pop.valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      kind_mem_r[wr_ptr_r] <= push.kind;
    end
  end

  `CSD_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "queue count beyond depth")
  `CSD_ASSERT(a_empty_ptrs, clk, rst_n, (count_r == '0) |-> (rd_ptr_r == wr_ptr_r), "empty queue with split pointers")
  `CSD_ASSERT(a_full_ptrs, clk, rst_n, (count_r == FULL_CNT) |-> (rd_ptr_r == wr_ptr_r), "full queue with split pointers")

endmodule

// ===== sv/csd_back.sv =====
// back end: phase machine, counters and registered result
`timescale 1ns / 1ps
`include "composite_sync_decoder_macros.svh"

module csd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csd_pkg::csd_xfer_t        pop,
  output logic                      pop_ready,
  input  logic [csd_pkg::CNT_W-1:0] pal_count,
  input  logic [csd_pkg::CNT_W-1:0] ntsc_count,
  csd_out_if.source                 out_ch
);
  import csd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] pulse_r, pulse_nxt;
  logic [CNT_W-1:0] std_r, std_nxt;
  logic             lock_r, lock_nxt;
  logic             field_r, field_nxt;
  logic [CNT_W-1:0] line_r, line_nxt;
  logic [CNT_W-1:0] active_lim_r, active_lim_nxt;
  logic [CNT_W-1:0] blank_lim_r, blank_lim_nxt;

  logic [CNT_W-1:0] pulse_inc;
  logic [CNT_W-1:0] line_inc;
  line_action_t     action;
  logic             fstart;
  logic             frstart;
  logic             fault;
  logic             pop_fire;

  logic             out_valid_r;
  pulse_kind_t      out_kind_r;
  logic [2:0]       out_phase_r;
  logic             out_lock_r;
  logic             out_field_r;
  logic [CNT_W-1:0] out_std_r;
  logic [CNT_W-1:0] out_line_r;
  line_action_t     out_action_r;
  logic             out_fstart_r;
  logic             out_frstart_r;
  logic             out_lost_r;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop_fire  = pop.valid && pop_ready;
  assign pulse_inc = sat_inc(pulse_r);
  assign line_inc  = sat_inc(line_r);

  always_comb begin
    phase_nxt      = phase_r;
    pulse_nxt      = pulse_r;
    std_nxt        = std_r;
    lock_nxt       = lock_r;
    field_nxt      = field_r;
    line_nxt       = line_r;
    active_lim_nxt = active_lim_r;
    blank_lim_nxt  = blank_lim_r;
    action         = ACT_NONE;
    fstart         = 1'b0;
    frstart        = 1'b0;
    fault          = 1'b0;

    unique case (pop.kind)
      KIND_HALF_LONG: begin
        if (phase_r == PH_BROAD) begin
          pulse_nxt = pulse_inc;
        end else if (phase_r == PH_PRE) begin
          // a long pre-equalizing run marks the even field
          field_nxt = (pulse_r > std_r) ? 1'b0 : 1'b1;
          phase_nxt = PH_BROAD;
          pulse_nxt = CNT_W'(1);
          fstart    = 1'b1;
          frstart   = !field_nxt;
        end else begin
          fault = 1'b1;
        end
      end
      KIND_HALF_SHORT: begin
        if (phase_r == PH_PRE) begin
          pulse_nxt = pulse_inc;
        end else if (phase_r == PH_POST) begin
          pulse_nxt = pulse_inc;
          if (pulse_inc == std_r) begin
            action = ACT_BLANK;
          end
        end else if (phase_r == PH_BROAD) begin
          lock_nxt = 1'b1;
          if (std_r != pulse_r) begin
            std_nxt = pulse_r;
            if (pulse_r == pal_count) begin
              active_lim_nxt = PAL_ACTIVE_LINES;
              blank_lim_nxt  = PAL_BLANK_LINES;
            end else if (pulse_r == ntsc_count) begin
              active_lim_nxt = NTSC_ACTIVE_LINES;
              blank_lim_nxt  = NTSC_BLANK_LINES;
            end
          end
          phase_nxt = PH_POST;
          pulse_nxt = CNT_W'(1);
        end else if (phase_r == PH_UNKNOWN || phase_r == PH_ACTIVE) begin
          phase_nxt = PH_PRE;
          pulse_nxt = CNT_W'(1);
          line_nxt  = '0;
        end else begin
          fault = 1'b1;
        end
      end
      KIND_FULL_SHORT: begin
        if (phase_r == PH_ACTIVE) begin
          line_nxt  = line_inc;
          pulse_nxt = pulse_inc;
          if (line_inc < blank_lim_r) begin
            action = ACT_BLANK;
          end else if (line_inc < active_lim_r) begin
            action = ACT_VIDEO;
          end
        end else if (phase_r == PH_POST) begin
          phase_nxt = PH_ACTIVE;
          pulse_nxt = CNT_W'(1);
          line_nxt  = CNT_W'(1);
        end else begin
          fault = 1'b1;
        end
      end
      KIND_FULL_LONG: begin
        fault = 1'b1;
      end
      default: begin
        fault = 1'b1;
      end
    endcase

    if (fault) begin
      lock_nxt  = 1'b0;
      phase_nxt = PH_UNKNOWN;
      pulse_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_UNKNOWN;
      pulse_r      <= '0;
      std_r        <= '0;
      lock_r       <= 1'b0;
      field_r      <= 1'b0;
      line_r       <= '0;
      active_lim_r <= '0;
      blank_lim_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop_fire) begin
        phase_r      <= phase_nxt;
        pulse_r      <= pulse_nxt;
        std_r        <= std_nxt;
        lock_r       <= lock_nxt;
        field_r      <= field_nxt;
        line_r       <= line_nxt;
        active_lim_r <= active_lim_nxt;
        blank_lim_r  <= blank_lim_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      out_kind_r    <= pop.kind;
      out_phase_r   <= phase_code(phase_nxt);
      out_lock_r    <= lock_nxt;
      out_field_r   <= field_nxt;
      out_std_r     <= std_nxt;
      out_line_r    <= line_nxt;
      out_action_r  <= action;
      out_fstart_r  <= fstart;
      out_frstart_r <= frstart;
      out_lost_r    <= fault;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pulse_kind     = out_kind_r;
  assign out_ch.sync_phase     = out_phase_r;
  assign out_ch.locked         = out_lock_r;
  assign out_ch.field_parity   = out_field_r;
  assign out_ch.standard_count = out_std_r;
  assign out_ch.line_number    = out_line_r;
  assign out_ch.line_action    = out_action_r;
  assign out_ch.field_start    = out_fstart_r;
  assign out_ch.frame_start    = out_frstart_r;
  assign out_ch.sync_lost      = out_lost_r;

  `CSD_ASSERT(a_phase_onehot, clk, rst_n, $onehot(phase_r), "phase register not one-hot")
  `CSD_ASSERT(a_lock_phase, clk, rst_n, lock_r |-> (phase_r != PH_UNKNOWN), "lock held in unknown phase")
  `CSD_ASSERT(a_lost_result, clk, rst_n, (out_valid_r && out_lost_r) |-> (!out_lock_r && out_phase_r == PHC_UNKNOWN), "sync loss result still locked")
  `CSD_NEVER(a_frame_field, clk, rst_n, out_valid_r && out_frstart_r && !out_fstart_r, "frame start without field start")

endmodule

// ===== sim/sync_decode_checker.sv =====
// scoreboard for the composite sync decoder: interval decoding prediction and result check
`timescale 1ns / 1ps

module sync_decode_checker
  import csd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  csd_in_if           in_ch,
  csd_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          error_count,
  output int          pending,
  output int          results_seen,
  output int          field_starts,
  output int          sync_losses,
  output int          video_lines
);

  localparam logic [THR_W-1:0] RESET_SHORT_THR  = 16'd839;
  localparam logic [THR_W-1:0] RESET_HALF_THR   = 16'd2855;
  localparam logic [CNT_W-1:0] RESET_PAL_BROAD  = 10'd5;
  localparam logic [CNT_W-1:0] RESET_NTSC_BROAD = 10'd6;

  localparam logic FIELD_EVEN = 1'b0;
  localparam logic FIELD_ODD  = 1'b1;

  typedef struct packed {
    pulse_kind_t       kind;
    logic [2:0]        phase;
    logic              locked;
    logic              parity;
    logic [CNT_W-1:0]  standard;
    logic [CNT_W-1:0]  line;
    line_action_t      action;
    logic              field_start;
    logic              frame_start;
    logic              lost;
  } decode_result_t;

  // register copies
  logic [THR_W-1:0] short_thr;
  logic [THR_W-1:0] half_thr;
  logic [CNT_W-1:0] pal_cnt;
  logic [CNT_W-1:0] ntsc_cnt;

  // decoder state
  logic [2:0]       phase_q;
  logic [CNT_W-1:0] pulse_cnt;
  logic [CNT_W-1:0] std_cnt;
  logic             lock_q;
  logic             field_q;
  logic [CNT_W-1:0] line_cnt;
  logic [CNT_W-1:0] active_lim;
  logic [CNT_W-1:0] blank_lim;

  decode_result_t pending_decodes[$];

  int mismatches = 0;
  int accepted_n = 0;
  int returned_n = 0;
  int fields_n   = 0;
  int losses_n   = 0;
  int video_n    = 0;

  assign error_count  = mismatches;
  assign pending      = accepted_n - returned_n;
  assign results_seen = returned_n;
  assign field_starts = fields_n;
  assign sync_losses  = losses_n;
  assign video_lines  = video_n;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic clear_decoder();
    short_thr  = RESET_SHORT_THR;
    half_thr   = RESET_HALF_THR;
    pal_cnt    = RESET_PAL_BROAD;
    ntsc_cnt   = RESET_NTSC_BROAD;
    phase_q    = PHC_UNKNOWN;
    pulse_cnt  = '0;
    std_cnt    = '0;
    lock_q     = 1'b0;
    field_q    = FIELD_EVEN;
    line_cnt   = '0;
    active_lim = '0;
    blank_lim  = '0;
  endtask

  // a count matching neither standard is kept but leaves the limits alone
  task automatic adopt_standard(input logic [CNT_W-1:0] count);
    std_cnt = count;
    if (std_cnt == pal_cnt) begin
      active_lim = PAL_ACTIVE_LINES;
      blank_lim  = PAL_BLANK_LINES;
    end else if (std_cnt == ntsc_cnt) begin
      active_lim = NTSC_ACTIVE_LINES;
      blank_lim  = NTSC_BLANK_LINES;
    end
  endtask

  task automatic decode_interval(input logic [THR_W-1:0] period,
                                 input logic [THR_W-1:0] width,
                                 output decode_result_t r);
    logic is_half_iv;
    logic is_short_iv;
    logic fault;
    pulse_kind_t kind;
    r = '0;
    fault = 1'b0;
    is_half_iv  = period <= half_thr;
    is_short_iv = width <= short_thr;
    if (is_half_iv) kind = is_short_iv ? KIND_HALF_SHORT : KIND_HALF_LONG;
    else            kind = is_short_iv ? KIND_FULL_SHORT : KIND_FULL_LONG;
    r.action = ACT_NONE;

    case (kind)
      KIND_HALF_LONG: begin
        if (phase_q == PHC_BROAD) begin
          pulse_cnt = count_up(pulse_cnt);
        end else if (phase_q == PHC_PRE) begin
          // more equalizing pulses than the standard count means the even field
          field_q = (pulse_cnt > std_cnt) ? FIELD_EVEN : FIELD_ODD;
          phase_q = PHC_BROAD;
          pulse_cnt = 10'd1;
          r.field_start = 1'b1;
          r.frame_start = (field_q == FIELD_EVEN);
        end else begin
          fault = 1'b1;
        end
      end
      KIND_HALF_SHORT: begin
        if (phase_q == PHC_PRE) begin
          pulse_cnt = count_up(pulse_cnt);
        end else if (phase_q == PHC_POST) begin
          pulse_cnt = count_up(pulse_cnt);
          if (pulse_cnt == std_cnt) r.action = ACT_BLANK;
        end else if (phase_q == PHC_BROAD) begin
          lock_q = 1'b1;
          if (std_cnt != pulse_cnt) adopt_standard(pulse_cnt);
          phase_q = PHC_POST;
          pulse_cnt = 10'd1;
        end else if (phase_q == PHC_UNKNOWN || phase_q == PHC_ACTIVE) begin
          phase_q = PHC_PRE;
          pulse_cnt = 10'd1;
          line_cnt = '0;
        end else begin
          fault = 1'b1;
        end
      end
      KIND_FULL_SHORT: begin
        if (phase_q == PHC_ACTIVE) begin
          line_cnt = count_up(line_cnt);
          pulse_cnt = count_up(pulse_cnt);
          if (line_cnt < blank_lim)       r.action = ACT_BLANK;
          else if (line_cnt < active_lim) r.action = ACT_VIDEO;
        end else if (phase_q == PHC_POST) begin
          phase_q = PHC_ACTIVE;
          pulse_cnt = 10'd1;
          line_cnt = 10'd1;
        end else begin
          fault = 1'b1;
        end
      end
      default: fault = 1'b1;
    endcase

    if (fault) begin
      lock_q = 1'b0;
      phase_q = PHC_UNKNOWN;
      pulse_cnt = '0;
      r.lost = 1'b1;
    end

    r.kind     = kind;
    r.phase    = phase_q;
    r.locked   = lock_q;
    r.parity   = field_q;
    r.standard = std_cnt;
    r.line     = line_cnt;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    decode_result_t want;
    if (!rst_n) begin
      clear_decoder();
      pending_decodes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHORT_THR:  short_thr = cfg_wdata;
          REG_HALF_THR:   half_thr  = cfg_wdata;
          REG_PAL_BROAD:  pal_cnt   = cfg_wdata[CNT_W-1:0];
          REG_NTSC_BROAD: ntsc_cnt  = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        decode_interval(in_ch.line_period, in_ch.sync_width, want);
        pending_decodes.push_back(want);
        accepted_n <= accepted_n + 1;
      end

      if (out_ch.valid && out_ch.ready) begin
        returned_n <= returned_n + 1;
        if (pending_decodes.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no interval outstanding", $time);
        end else begin
          want = pending_decodes.pop_front();
          compare_field("pulse_kind", want.kind, out_ch.pulse_kind);
          compare_field("sync_phase", want.phase, out_ch.sync_phase);
          compare_field("locked", want.locked, out_ch.locked);
          compare_field("field_parity", want.parity, out_ch.field_parity);
          compare_field("standard_count", want.standard, out_ch.standard_count);
          compare_field("line_number", want.line, out_ch.line_number);
          compare_field("line_action", want.action, out_ch.line_action);
          compare_field("field_start", want.field_start, out_ch.field_start);
          compare_field("frame_start", want.frame_start, out_ch.frame_start);
          compare_field("sync_lost", want.lost, out_ch.sync_lost);
        end
        if (out_ch.field_start === 1'b1) fields_n++;
        if (out_ch.sync_lost === 1'b1) losses_n++;
        if (out_ch.line_action === ACT_VIDEO) video_n++;
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// top of the composite sync decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top
  import csd_pkg::*;
();

  localparam int STALL_LIMIT   = 1000;  // cycles with no transfer on either channel
  localparam int SETTLE_CYCLES = 4;     // margin after the last result comes back

  localparam logic [15:0] DEFAULT_SHORT_THR  = 16'd839;
  localparam logic [15:0] DEFAULT_HALF_THR   = 16'd2855;
  localparam logic [15:0] DEFAULT_PAL_BROAD  = 16'd5;
  localparam logic [15:0] DEFAULT_NTSC_BROAD = 16'd6;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  csd_in_if  in_ch();
  csd_out_if out_ch();

  // register values as last written, used to aim pulses at each class
  logic [15:0] short_thr = DEFAULT_SHORT_THR;
  logic [15:0] half_thr  = DEFAULT_HALF_THR;
  logic [9:0]  pal_cnt   = DEFAULT_PAL_BROAD[9:0];
  logic [9:0]  ntsc_cnt  = DEFAULT_NTSC_BROAD[9:0];

  bit steady = 1'b0;  // when set neither side inserts idle cycles
  int items_sent = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  int error_count, pending, results_seen, field_starts, sync_losses, video_lines;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  composite_sync_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sync_decode_checker decode_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .error_count  (error_count),
    .pending      (pending),
    .results_seen (results_seen),
    .field_starts (field_starts),
    .sync_losses  (sync_losses),
    .video_lines  (video_lines)
  );

  // ---------------------------------------------------------------------------
  // pulse shaping: pick a period or width on a chosen side of a threshold,
  // with the threshold itself and the range ends drawn often
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] pick_at_most(input logic [15:0] thr);
    case ($urandom_range(7, 0))
      0: return thr;
      1: return 16'd0;
      default: return 16'($urandom_range(thr, 0));
    endcase
  endfunction

  function automatic logic [15:0] pick_above(input logic [15:0] thr);
    // nothing lies above the top of the range, the class is then unreachable
    if (thr == 16'hFFFF) return thr;
    case ($urandom_range(7, 0))
      0: return thr + 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF, thr + 1));
    endcase
  endfunction

  // broad pulse count of a field: mostly one of the two known standards
  function automatic int pick_broad_count();
    int count;
    case ($urandom_range(3, 0))
      0, 1:    count = int'(pal_cnt);
      2:       count = int'(ntsc_cnt);
      default: count = $urandom_range(12, 1);
    endcase
    // keep fields short when a register holds a huge count
    if (count == 0 || count > 40) count = $urandom_range(12, 1);
    return count;
  endfunction

  // ---------------------------------------------------------------------------
  // input channel driver: random idle gap unless steady, then hold valid until
  // the transfer; valid stays high across back-to-back intervals
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [15:0] period, input logic [15:0] width);
    int gap;
    gap = steady ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.line_period <= period;
    in_ch.sync_width  <= width;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_kind(input pulse_kind_t kind);
    logic want_half;
    logic want_short;
    want_half  = (kind == KIND_HALF_LONG) || (kind == KIND_HALF_SHORT);
    want_short = (kind == KIND_HALF_SHORT) || (kind == KIND_FULL_SHORT);
    send_item(want_half ? pick_at_most(half_thr) : pick_above(half_thr),
              want_short ? pick_at_most(short_thr) : pick_above(short_thr));
  endtask

  // one vertical interval: pre-equalizing, broad, post-equalizing, then lines
  task automatic send_field(input int n_pre, input int n_broad, input int n_post,
                            input int n_lines);
    repeat (n_pre)   send_kind(KIND_HALF_SHORT);
    repeat (n_broad) send_kind(KIND_HALF_LONG);
    repeat (n_post)  send_kind(KIND_HALF_SHORT);
    repeat (n_lines) send_kind(KIND_FULL_SHORT);
  endtask

  // either a pulse of random class or raw values over the whole field range
  task automatic send_noise();
    if ($urandom_range(1, 0))
      send_kind(pulse_kind_t'($urandom_range(3, 0)));
    else
      send_item(16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)));
  endtask

  // mostly well-formed fields with random sizes, the rest broken fields and noise
  task automatic run_fields(input int budget);
    int start_count;
    int sel;
    int n_lines;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      steady = ($urandom_range(3, 0) == 0);
      sel = $urandom_range(9, 0);
      // now and then a long field that can cross both line limits
      n_lines = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 240)
                                             : $urandom_range(30, 0);
      if (sel < 7) begin
        send_field($urandom_range(8, 1), pick_broad_count(), $urandom_range(8, 1),
                   n_lines);
      end else if (sel < 9) begin
        // truncated or out-of-order interval followed by a stray pulse
        send_field($urandom_range(8, 0), $urandom_range(1, 0) ? pick_broad_count() : 0,
                   $urandom_range(3, 0), $urandom_range(3, 0));
        send_noise();
      end else begin
        repeat ($urandom_range(5, 1)) send_noise();
      end
    end
    steady = 1'b0;
  endtask

  // drop valid, let every outstanding result come back, then settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four registers on consecutive cycles, only while idle
  task automatic set_registers(input logic [15:0] short_val, input logic [15:0] half_val,
                               input logic [15:0] pal_val, input logic [15:0] ntsc_val);
    logic [1:0]  reg_order [4];
    logic [15:0] reg_value [4];
    reg_order = '{REG_SHORT_THR, REG_HALF_THR, REG_PAL_BROAD, REG_NTSC_BROAD};
    reg_value = '{short_val, half_val, pal_val, ntsc_val};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_wdata <= reg_value[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    short_thr = short_val;
    half_thr  = half_val;
    pal_cnt   = pal_val[9:0];
    ntsc_cnt  = ntsc_val[9:0];
    settings_used++;
  endtask

  // hand-picked opening at reset values: boundaries of both thresholds,
  // every class, loss of sync with and without lock, a complete field
  task automatic run_directed();
    send_item(16'hFFFF, 16'hFFFF);           // full line, long sync from unknown
    send_item(16'd0, 16'hFFFF);              // broad pulse with no equalizing first
    send_item(half_thr + 16'd1, short_thr);  // line pulse outside active video
    // six pre-equalizing pulses, more than the unknown standard: even field
    for (int i = 0; i < 6; i++)
      send_item(i[0] ? 16'd0 : half_thr, i[0] ? short_thr : 16'd0);
    // five broad pulses: learns the 625-line standard
    for (int i = 0; i < 5; i++)
      send_item(i[0] ? 16'd0 : half_thr, i[0] ? 16'hFFFF : short_thr + 16'd1);
    // post-equalizing run that reaches the standard count
    for (int i = 0; i < 5; i++)
      send_kind(KIND_HALF_SHORT);
    send_item(half_thr + 16'd1, 16'd0);
    send_item(16'hFFFF, short_thr);
    send_kind(KIND_FULL_SHORT);
    send_item(16'h8000, short_thr + 16'd1);  // full line, long sync while locked
  endtask

  // ---------------------------------------------------------------------------
  // result channel: unless steady, ready drops for a random stall before each result
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(3, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog: ends a run in which neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_SHORT_THR;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.line_period = '0;
    in_ch.sync_width  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values
    run_directed();
    run_fields(200);
    wait_idle();

    // random thresholds; upper bits of the broad count write are dropped
    set_registers($urandom_range(2000, 200), $urandom_range(8000, 1000),
                  16'hFC05, DEFAULT_NTSC_BROAD);
    run_fields(250);
    wait_idle();

    // both standards share one count: the 625-line limits win
    set_registers($urandom_range(1500, 300), $urandom_range(6000, 1500), 16'd4, 16'd4);
    run_fields(200);
    wait_idle();

    // lowest thresholds, and broad counts that no field matches
    set_registers(16'd0, 16'd0, 16'hFFFF, 16'd0);
    run_fields(150);
    wait_idle();

    // highest thresholds: every interval is a half line with short sync
    set_registers(16'hFFFF, 16'hFFFF, DEFAULT_PAL_BROAD, DEFAULT_NTSC_BROAD);
    run_fields(80);
    wait_idle();

    // 625-line count at the top of its range, 525-line count of seven
    set_registers(DEFAULT_SHORT_THR, DEFAULT_HALF_THR, 16'h03FF, 16'd7);
    run_fields(120);
    wait_idle();

    $display("run: %0d intervals under %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("run: %0d field starts, %0d sync losses, %0d video-line actions",
             field_starts, sync_losses, video_lines);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== composite_sync_decoder.f =====
+incdir+sv
sv/csd_pkg.sv
sv/csd_if.sv
sv/csd_front.sv
sv/csd_queue.sv
sv/csd_back.sv
sv/composite_sync_decoder.sv
sim/sync_decode_checker.sv
sim/tb_top.sv
